/* rtl/core/csld_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the camera sync-code line deframer.
// No dependencies; imported by csld_parse and camera_sync_code_line_deframer.
package csld_pkg;

	// Frame buffer size in bytes and the address span that the output covers
	localparam int unsigned BUFFER_BYTES = 131072;
	localparam int unsigned ADDR_W       = 17;
	localparam int unsigned BASE_W       = ADDR_W + 1;
	localparam int unsigned ADDR_SPAN    = 1 << ADDR_W;
	localparam int unsigned ADDR_LIMIT   =
		(BUFFER_BYTES < ADDR_SPAN) ? BUFFER_BYTES : ADDR_SPAN;

	localparam int unsigned LEN_W   = 12;
	localparam int unsigned RUN_W   = 4;
	localparam int unsigned CODE_W  = 8;
	localparam int unsigned CFG_IDX_W = 3;

	// Byte values of the serial stream
	localparam logic [CODE_W-1:0] SYNC_FILL = 8'hFF;
	localparam logic [RUN_W-1:0]  RUN_MAX   = 4'd15;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_RUN_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_CODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_CODE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_CODE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_CODE    = 3'd5;

	// Configuration reset values
	localparam logic [LEN_W-1:0]  LINE_LENGTH_RST  = 12'd240;
	localparam logic [RUN_W-1:0]  SYNC_RUN_MIN_RST = 4'd3;
	localparam logic [CODE_W-1:0] FRAME_CODE_RST   = 8'h01;
	localparam logic [CODE_W-1:0] LINE_CODE_RST    = 8'h02;
	localparam logic [CODE_W-1:0] DATA_CODE_RST    = 8'h40;
	localparam logic [CODE_W-1:0] LAST_CODE_RST    = 8'h00;

	typedef struct packed {
		logic [LEN_W-1:0]  line_length;
		logic [RUN_W-1:0]  sync_run_min;
		logic [CODE_W-1:0] frame_code;
		logic [CODE_W-1:0] line_code;
		logic [CODE_W-1:0] data_code;
		logic [CODE_W-1:0] last_code;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] write_addr;
		logic [CODE_W-1:0] pixel;
		logic              frame_end;
		logic              overflow;
	} res_t;

endpackage

/* rtl/core/csld_parse.sv */
`timescale 1ns / 1ps
// Sync-code parser: phase tracking, FF-run counting and buffer address generation.
// Depends on csld_pkg for the configuration and result structs.
module csld_parse (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [csld_pkg::CODE_W-1:0] rx_byte,
	input  csld_pkg::cfg_t           cfg,
	output csld_pkg::res_t           res
);
	import csld_pkg::*;

	typedef enum logic [2:0] {
		HUNT_FRAME,
		WAIT_LINE,
		WAIT_DATA,
		LINE_DATA,
		LAST_DATA
	} phase_t;

	localparam logic [BASE_W-1:0] LIMIT_B   = BASE_W'(ADDR_LIMIT);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ADDR_LIMIT - 1);

	phase_t            phase_q, phase_d;
	logic [RUN_W-1:0]  ff_run_q, ff_run_d;
	logic              keep_par_q, keep_par_d;
	logic              byte_par_q;
	logic [LEN_W-1:0]  column_q, column_d;
	logic [BASE_W-1:0] line_base_q, line_base_d;

	logic              in_line;
	logic [LEN_W-1:0]  len;
	logic [BASE_W-1:0] addr_sum;
	logic [BASE_W-1:0] base_sum;
	logic [LEN_W-1:0]  col_inc;
	logic              line_end;
	logic              addr_ovf;

	// Address and end-of-line arithmetic for the current byte
	always_comb begin
		in_line  = (phase_q == LINE_DATA) || (phase_q == LAST_DATA);
		len      = (cfg.line_length == '0) ? LEN_W'(1) : cfg.line_length;
		addr_sum = line_base_q + BASE_W'(column_q);
		addr_ovf = (addr_sum >= LIMIT_B);
		col_inc  = column_q + LEN_W'(1);
		line_end = (col_inc >= len) || (col_inc == '0);
		base_sum = line_base_q + BASE_W'(len);
	end

	// Next state and result for the byte in flight
	always_comb begin
		phase_d     = phase_q;
		ff_run_d    = ff_run_q;
		keep_par_d  = keep_par_q;
		column_d    = column_q;
		line_base_d = line_base_q;
		res.valid      = 1'b0;
		res.write_addr = addr_ovf ? LAST_ADDR : addr_sum[ADDR_W-1:0];
		res.pixel      = rx_byte;
		res.frame_end  = 1'b0;
		res.overflow   = addr_ovf;

		if (in_line) begin
			ff_run_d = '0;
			if (byte_par_q == keep_par_q) begin
				res.valid = 1'b1;
				column_d  = col_inc;
				if (line_end) begin
					column_d = '0;
					if (phase_q == LAST_DATA) begin
						res.frame_end = 1'b1;
						line_base_d   = '0;
						phase_d       = HUNT_FRAME;
					end else begin
						line_base_d = (base_sum > LIMIT_B) ? LIMIT_B : base_sum;
						phase_d     = WAIT_LINE;
					end
				end
			end
		end else if (rx_byte == SYNC_FILL) begin
			// count the fill run, saturating
			if (ff_run_q != RUN_MAX) begin
				ff_run_d = ff_run_q + RUN_W'(1);
			end
		end else begin
			ff_run_d = '0;
			if (ff_run_q >= cfg.sync_run_min) begin
				unique case (phase_q)
					HUNT_FRAME: begin
						if (rx_byte == cfg.frame_code) phase_d = WAIT_LINE;
					end
					WAIT_LINE: begin
						if (rx_byte == cfg.line_code) phase_d = WAIT_DATA;
					end
					default: begin
						if (rx_byte == cfg.last_code) begin
							phase_d    = LAST_DATA;
							keep_par_d = byte_par_q;
						end else if (rx_byte == cfg.data_code) begin
							phase_d    = LINE_DATA;
							keep_par_d = byte_par_q;
						end
					end
				endcase
			end
		end
	end

	// Advance parser state once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= HUNT_FRAME;
			ff_run_q    <= '0;
			keep_par_q  <= 1'b0;
			byte_par_q  <= 1'b0;
			column_q    <= '0;
			line_base_q <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			ff_run_q    <= ff_run_d;
			keep_par_q  <= keep_par_d;
			byte_par_q  <= ~byte_par_q;
			column_q    <= column_d;
			line_base_q <= line_base_d;
		end
	end

	// Line base saturates at the buffer limit
	assert property (@(posedge clk) disable iff (!arst_n) line_base_q <= LIMIT_B)
		else $error("line base past buffer limit");

	// FF run stays cleared while line data is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == LINE_DATA || phase_q == LAST_DATA) |-> ff_run_q == '0)
		else $error("ff run nonzero during line data");

	// Column is only nonzero inside a line
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == HUNT_FRAME || phase_q == WAIT_LINE || phase_q == WAIT_DATA)
		|-> column_q == '0)
		else $error("column nonzero outside line data");

	// Frame end returns to frame hunting with the base rewound
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.valid && res.frame_end) |=> (phase_q == HUNT_FRAME && line_base_q == '0))
		else $error("frame end did not restart frame hunt");

endmodule

/* rtl/core/camera_sync_code_line_deframer.sv */
`timescale 1ns / 1ps
// Top level of the camera sync-code line deframer: config registers, input and result registers.
// Depends on csld_pkg and csld_parse.
//
// Usage:
//   Camera bytes enter on rx_byte with byte_valid/byte_ready; kept image bytes leave on
//   write_addr/pixel/frame_end/overflow with pixel_valid/pixel_ready. Most bytes (fill,
//   codes, skipped bytes) produce no result transaction.
//   Registers are written through cfg_wen/cfg_idx/cfg_wdata, one per cycle; the user must write
//   them only while the block is idle, which the block does not enforce; unknown indexes are ignored.
//   Path: a byte accepted into the input register is parsed from there, and its result, if any,
//   is loaded into the result register.
//   Throughput: one byte per cycle while no result waits on pixel_ready. The parser state update is a single
//   add/compare level between the input register and the result register.
//   Stall: while a result waits on pixel_ready, the byte in the input register holds
//   and byte_ready drops; a byte that is parsed while the result register is being
//   emptied flows through without a bubble.
//   Reset: arst_n clears parser state to frame hunting, the registers to their defaults
//   and both valids; no clearing pass, the block is ready right after reset.
module camera_sync_code_line_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	output logic                           byte_ready,
	input  logic [csld_pkg::CODE_W-1:0]    rx_byte,
	output logic                           pixel_valid,
	input  logic                           pixel_ready,
	output logic [csld_pkg::ADDR_W-1:0]    write_addr,
	output logic [csld_pkg::CODE_W-1:0]    pixel,
	output logic                           frame_end,
	output logic                           overflow,
	input  logic                           cfg_wen,
	input  logic [csld_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [csld_pkg::LEN_W-1:0]     cfg_wdata
);
	import csld_pkg::*;

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [CODE_W-1:0] byte_s1;
	logic              res_valid_q;
	res_t              res_q;
	res_t              res;
	logic              adv;
	logic              step;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_length  <= LINE_LENGTH_RST;
			cfg_q.sync_run_min <= SYNC_RUN_MIN_RST;
			cfg_q.frame_code   <= FRAME_CODE_RST;
			cfg_q.line_code    <= LINE_CODE_RST;
			cfg_q.data_code    <= DATA_CODE_RST;
			cfg_q.last_code    <= LAST_CODE_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_LINE_LENGTH:  cfg_q.line_length  <= cfg_wdata;
				REG_SYNC_RUN_MIN: cfg_q.sync_run_min <= cfg_wdata[RUN_W-1:0];
				REG_FRAME_CODE:   cfg_q.frame_code   <= cfg_wdata[CODE_W-1:0];
				REG_LINE_CODE:    cfg_q.line_code    <= cfg_wdata[CODE_W-1:0];
				REG_DATA_CODE:    cfg_q.data_code    <= cfg_wdata[CODE_W-1:0];
				REG_LAST_CODE:    cfg_q.last_code    <= cfg_wdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the input register when the result register is free or draining
	assign adv        = !res_valid_q || pixel_ready;
	assign step       = valid_s1 && adv;
	assign byte_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	csld_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	// Result register: load a new transaction or drop the one taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			res_q <= res;
		end
	end

	assign pixel_valid = res_valid_q;
	assign write_addr  = res_q.write_addr;
	assign pixel       = res_q.pixel;
	assign frame_end   = res_q.frame_end;
	assign overflow    = res_q.overflow;

	// A byte waiting in the input register is never parsed while a result is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !pixel_ready) |-> !step)
		else $error("byte parsed into a stalled result register");

	// A parsed byte with a result always shows up on the output next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.valid) |=> res_valid_q)
		else $error("parsed result lost");

	// A stalled byte in the input register keeps its slot
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled input byte lost");

endmodule
